// ===== hdl/lzw_stream_encoder_unit_defines.svh =====
// Assertion macros for the LZW stream encoder.
`ifndef LZW_STREAM_ENCODER_UNIT_DEFINES_SVH
`define LZW_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZWE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZWE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lzwe_pkg.sv =====
// Shared types, constants and the slot hash for the LZW stream encoder.
package lzwe_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int DICT_SLOTS_DEF    = 8192;
    localparam int BYTE_W            = 8;
    localparam int CODE_OUT_W        = 12;
    localparam int WIDTH_OUT_W       = 4;
    localparam int WIDTH_REG_W       = 5;
    localparam int START_WIDTH       = 8;
    localparam int FIRST_FREE_CODE   = 256;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [11:0] code_value;
        logic [3:0]  code_width;
        logic        final_code;
    } t_out_item;

    // Hashed start slot of a (prefix, byte) pair; caller keeps the low bits.
    function automatic logic [31:0] slot_hash(input logic [31:0] pfx,
                                              input logic [7:0]  data);
        logic [31:0] h_mul;
        logic [31:0] h_byte;
        h_mul  = pfx * 32'h0000_9E37;
        h_byte = {24'd0, data} * 32'h0000_0101;
        return h_mul ^ h_byte ^ (pfx >> 5);
    endfunction

endpackage

// ===== hdl/lzwe_dict.sv =====
// Dictionary slot memory: one write port, one registered read port.
module lzwe_dict
    import lzwe_pkg::*;
#(
    parameter int ADDR_W  = 13,
    parameter int ENTRY_W = 33
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [(2**ADDR_W)-1:0];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lzw_stream_encoder_unit.sv =====
// Top level of the LZW stream encoder: sequencer, state registers, output item register.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_item) takes one byte per item,
//    with end_of_stream set on the last byte of a stream.
//  - Output channel (o_out_valid / i_out_stall / o_out_item) gives codes with their
//    width; final_code marks the last code of a stream. An item yields 0, 1 or 2 codes.
//  - Each byte after the first passes an accept state, a hash state and, per
//    dictionary probe, a read and a check state, plus an emit state on a miss.
//    Extra probes come from linear probing in the slot memory.
//    A code is valid the cycle after it is made.
//  - The output register holds a code until taken; while it is stalled the sequencer
//    waits in its emit state and the input stays stalled.
//  - Reset and every end of stream run a clearing pass over every slot of the
//    slot memory with o_in_stall high. The dictionary then starts empty.
//  - DICT_SLOTS must be a power of two.
`include "lzw_stream_encoder_unit_defines.svh"

module lzw_stream_encoder_unit
    import lzwe_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int DICT_SLOTS    = DICT_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ADDR_W  = $clog2(DICT_SLOTS);
    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int ENTRY_W = 1 + CODE_W + BYTE_W + CODE_W;

    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_HASH      = 7'b0000100,
        S_READ      = 7'b0001000,
        S_CHECK     = 7'b0010000,
        S_EMIT_MISS = 7'b0100000,
        S_EMIT_FIN  = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]      r_probe, n_probe;
    logic [CODE_W-1:0]      r_prefix, n_prefix;
    logic                   r_prefix_valid, n_prefix_valid;
    logic [CODE_W:0]        r_next_free, n_next_free;
    logic [WIDTH_REG_W-1:0] r_width, n_width;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic                   r_last, n_last;
    logic                   r_ins, n_ins;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   ent_valid;
    logic [CODE_W-1:0]      ent_prefix;
    logic [BYTE_W-1:0]      ent_byte;
    logic [CODE_W-1:0]      ent_code;
    logic                   out_free;
    logic                   out_load;
    logic                   in_accept;
    logic [31:0]            hash_full;
    logic [CODE_W:0]        inc_free;

    lzwe_dict #(
        .ADDR_W  (ADDR_W),
        .ENTRY_W (ENTRY_W)
    ) u_dict (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign {ent_valid, ent_prefix, ent_byte, ent_code} = rd_data;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign hash_full   = slot_hash(32'(r_prefix), r_byte);
    assign inc_free    = r_next_free + (CODE_W+1)'(1);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_probe        = r_probe;
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_next_free    = r_next_free;
        n_width        = r_width;
        n_byte         = r_byte;
        n_last         = r_last;
        n_ins          = r_ins;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_item     = r_out_item;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = r_addr;
        wr_data        = {r_ins, r_prefix, r_byte, r_next_free[CODE_W-1:0]};

        case (r_state)
            S_CLEAR: begin
                // sweep: one slot cleared per cycle
                wr_en   = 1'b1;
                wr_data = '0;
                n_addr  = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(DICT_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_byte = i_in_item.data_byte;
                    n_last = i_in_item.end_of_stream;
                    if (!r_prefix_valid) begin
                        n_prefix       = CODE_W'(i_in_item.data_byte);
                        n_prefix_valid = 1'b1;
                        if (i_in_item.end_of_stream) begin
                            n_state = S_EMIT_FIN;
                        end
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_addr  = hash_full[ADDR_W-1:0];
                n_probe = '0;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!ent_valid) begin
                    // empty slot ends the probe; insert here if codes remain
                    n_ins   = !r_next_free[CODE_W];
                    n_state = S_EMIT_MISS;
                end else if (ent_prefix == r_prefix && ent_byte == r_byte) begin
                    n_prefix = ent_code;
                    n_state  = r_last ? S_EMIT_FIN : S_IDLE;
                end else if (r_probe == ADDR_W'(DICT_SLOTS - 1)) begin
                    // table full: emit, no insert
                    n_ins   = 1'b0;
                    n_state = S_EMIT_MISS;
                end else begin
                    n_probe = r_probe + ADDR_W'(1);
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_READ;
                end
            end
            S_EMIT_MISS: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_item  = '{code_value: CODE_OUT_W'(r_prefix),
                                    code_width: r_width[WIDTH_OUT_W-1:0],
                                    final_code: 1'b0};
                    wr_en       = r_ins;
                    if (r_ins) begin
                        n_next_free = inc_free;
                        if (r_width < WIDTH_REG_W'(MAX_CODE_BITS) &&
                            inc_free > ((CODE_W+1)'(1) << r_width)) begin
                            n_width = r_width + WIDTH_REG_W'(1);
                        end
                    end
                    n_prefix = CODE_W'(r_byte);
                    n_state  = r_last ? S_EMIT_FIN : S_IDLE;
                end
            end
            S_EMIT_FIN: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_item     = '{code_value: CODE_OUT_W'(r_prefix),
                                       code_width: r_width[WIDTH_OUT_W-1:0],
                                       final_code: 1'b1};
                    // back to the reset state, dictionary swept again
                    n_prefix       = '0;
                    n_prefix_valid = 1'b0;
                    n_next_free    = (CODE_W+1)'(FIRST_FREE_CODE);
                    n_width        = WIDTH_REG_W'(START_WIDTH);
                    n_addr         = '0;
                    n_state        = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_addr         <= '0;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_next_free    <= (CODE_W+1)'(FIRST_FREE_CODE);
            r_width        <= WIDTH_REG_W'(START_WIDTH);
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_addr         <= n_addr;
            r_prefix       <= n_prefix;
            r_prefix_valid <= n_prefix_valid;
            r_next_free    <= n_next_free;
            r_width        <= n_width;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_probe    <= n_probe;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_ins      <= n_ins;
        r_out_item <= n_out_item;
    end

    `LZWE_ASSERT_IMPL(a_width_range, i_clk, i_rst_n, 1'b1, (r_width >= WIDTH_REG_W'(START_WIDTH) && r_width <= WIDTH_REG_W'(MAX_CODE_BITS)), "code width out of range")
    `LZWE_ASSERT_IMPL(a_free_bound, i_clk, i_rst_n, 1'b1, (r_next_free <= ((CODE_W+1)'(1) << CODE_W)), "next free code past limit")
    `LZWE_ASSERT_NEXT(a_fin_resets, i_clk, i_rst_n, (r_state == S_EMIT_FIN && out_load), (r_state == S_CLEAR && !r_prefix_valid && o_out_item.final_code), "final code did not restart stream")
    `LZWE_ASSERT_IMPL(a_no_load_over_full, i_clk, i_rst_n, (out_load && r_out_valid), !i_out_stall, "output item overwritten while stalled")

endmodule

// ===== sim/tb_lzw_stream_encoder_unit.sv =====
// Testbench for the LZW stream encoder: directed and random byte streams, scoreboard check.
`timescale 1ns / 100ps

module tb_lzw_stream_encoder_unit;
    import lzwe_pkg::*;

    localparam int SLOTS      = 8192;
    localparam int CODE_LIMIT = 4096;
    localparam int MAX_BITS   = 12;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 64;

    // idling profiles: sender/receiver duty
    typedef enum int { IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE } t_idle_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    lzw_stream_encoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- encoder shadow state ----
    logic [11:0] enc_prefix;
    logic        enc_prefix_ok;
    logic [12:0] enc_next_code;
    logic [3:0]  enc_width;
    logic        slot_used [SLOTS];
    logic [11:0] slot_prefix [SLOTS];
    logic [7:0]  slot_byte [SLOTS];
    logic [11:0] slot_code [SLOTS];

    t_out_item   pending_codes[$];
    t_idle_mode  idle_mode = IDLE_NONE;
    int          hold_cycles = 0;
    int          mismatches = 0;
    int          codes_seen = 0;
    int          bytes_sent = 0;
    int          streams_done = 0;
    int          cycle_count = 0;
    int          max_width_seen = 0;

    function automatic void clear_encoder();
        enc_prefix    = '0;
        enc_prefix_ok = 1'b0;
        enc_next_code = 13'd256;
        enc_width     = 4'd8;
        for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
    endfunction

    function automatic void push_code(logic [11:0] c, logic [3:0] w, logic f);
        t_out_item o;
        o.code_value = c;
        o.code_width = w;
        o.final_code = f;
        pending_codes = {pending_codes, o};
        if (w > max_width_seen) max_width_seen = w;
    endfunction

    // Encode one byte: hashed lookup with linear probing, then insert on miss.
    function automatic void encode_byte(t_in_item it);
        logic [31:0] h;
        int          start, s, free_s;
        logic        hit;
        logic [11:0] hit_code;
        hit = 1'b0;
        hit_code = '0;
        free_s = SLOTS;
        if (!enc_prefix_ok) begin
            enc_prefix    = {4'd0, it.data_byte};
            enc_prefix_ok = 1'b1;
        end else begin
            h = ({20'd0, enc_prefix} * 32'h9E37) ^ ({24'd0, it.data_byte} * 32'h0101)
                ^ ({20'd0, enc_prefix} >> 5);
            start = h % SLOTS;
            for (int i = 0; i < SLOTS; i++) begin
                s = (start + i) % SLOTS;
                if (!slot_used[s]) begin
                    free_s = s;
                    break;
                end
                if (slot_prefix[s] == enc_prefix && slot_byte[s] == it.data_byte) begin
                    hit = 1'b1;
                    hit_code = slot_code[s];
                    break;
                end
            end
            if (hit) begin
                enc_prefix = hit_code;
            end else begin
                push_code(enc_prefix, enc_width, 1'b0);
                if (enc_next_code < CODE_LIMIT && free_s < SLOTS) begin
                    slot_used[free_s]   = 1'b1;
                    slot_prefix[free_s] = enc_prefix;
                    slot_byte[free_s]   = it.data_byte;
                    slot_code[free_s]   = enc_next_code[11:0];
                    enc_next_code++;
                    if (enc_width < MAX_BITS && enc_next_code > (13'd1 << enc_width))
                        enc_width++;
                end
                enc_prefix = {4'd0, it.data_byte};
            end
        end
        if (it.end_of_stream) begin
            push_code(enc_prefix, enc_width, 1'b1);
            clear_encoder();
            streams_done++;
        end
    endfunction

    // ---- receiver: random stall per profile, long hold-off on request ----
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_SEND_LIGHT: i_out_stall <= ($urandom_range(99) < 85);
                IDLE_SEND_HEAVY: i_out_stall <= ($urandom_range(99) < 8);
                default:         i_out_stall <= 1'b0;
            endcase
        end
    end

    // ---- code checker ----
    always @(posedge i_clk) begin
        t_out_item exp_code;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            codes_seen++;
            if (pending_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code %h width %0d final %b",
                             o_out_item.code_value, o_out_item.code_width,
                             o_out_item.final_code);
            end else begin
                exp_code = pending_codes.pop_front();
                if (exp_code.code_value != o_out_item.code_value ||
                    exp_code.code_width != o_out_item.code_width ||
                    exp_code.final_code != o_out_item.final_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("code %0d: exp %h/%0d/%b got %h/%0d/%b", codes_seen,
                                 exp_code.code_value, exp_code.code_width,
                                 exp_code.final_code, o_out_item.code_value,
                                 o_out_item.code_width, o_out_item.final_code);
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lzw_stream_encoder_unit: mismatch");
            $finish;
        end
    end

    // Offer one byte, hold it until taken, then run it through the shadow encoder.
    task automatic send_byte(logic [7:0] b, logic eos);
        t_in_item it;
        int pct;
        it.data_byte = b;
        it.end_of_stream = eos;
        case (idle_mode)
            IDLE_SEND_LIGHT: pct = 8;
            IDLE_SEND_HEAVY: pct = 85;
            default:         pct = 0;
        endcase
        if ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        encode_byte(it);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
    endtask

    // Random stream; small alphabets give dictionary hits and long codes.
    task automatic send_stream(int len);
        int alpha;
        alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(3, 1);
        for (int i = 0; i < len; i++)
            send_byte((alpha == 255) ? 8'($urandom) : 8'($urandom_range(alpha)),
                      i == len - 1);
    endtask

    task automatic test_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_hits_and_misses();
        // repeated byte builds chains of hits; then 0x00/0xFF pairs
        for (int i = 0; i < 8; i++) send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        // two-byte stream: miss then final
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);
        wait_drained();
    endtask

    task automatic test_width_growth();
        // enough misses to pass 512 codes and reach 10-bit codes
        for (int i = 0; i < 300; i++) send_byte(8'($urandom), i == 299);
        wait_drained();
    endtask

    task automatic test_random_streams(t_idle_mode m, int nbytes);
        int sent;
        int len;
        idle_mode = m;
        sent = 0;
        while (sent < nbytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(25, 2);
            send_stream(len);
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_encoder();
        @(posedge i_clk);

        test_single_byte_streams();
        test_hits_and_misses();
        wait_drained();
        test_backpressure();
        test_width_growth();
        test_random_streams(IDLE_SEND_LIGHT, 80);
        test_random_streams(IDLE_SEND_HEAVY, 80);
        test_random_streams(IDLE_NONE, 80);

        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d bytes in %0d streams, checked %0d codes, widest %0d bits",
                 bytes_sent, streams_done, codes_seen, max_width_seen);
        $display("idling profiles covered, long receiver hold-off and full drains included");
        if (mismatches == 0 && pending_codes.size() == 0) begin
            $display("lzw_stream_encoder_unit: match");
        end else begin
            $display("lzw_stream_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lzwe_pkg.sv
hdl/lzwe_dict.sv
hdl/lzw_stream_encoder_unit.sv
sim/tb_lzw_stream_encoder_unit.sv
